// File: hw/rtl/lphs_pkg.sv
package lphs_pkg;

   // Field widths of the request, response and configuration ports.
   localparam int CMD_W     = 2;
   localparam int KEY_W     = 31;
   localparam int STATUS_W  = 2;
   localparam int COUNT_W   = 7;
   localparam int SIZE_W    = 7;
   localparam int TAG_W     = 2;
   localparam int SLOT_W    = TAG_W + KEY_W;
   localparam int KEY_BIT_W = $clog2(KEY_W);

   // Default store depth and the table size after reset.
   localparam int MAX_SLOTS_DEFAULT = 64;
   localparam logic [SIZE_W-1:0] TABLE_SIZE_RESET = SIZE_W'(64);

   // Request commands.
   typedef enum logic [CMD_W-1:0] {
      CMD_SEARCH = 2'd0,
      CMD_INSERT = 2'd1,
      CMD_DELETE = 2'd2
   } cmd_type;

   // Response status codes.
   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_PRESENT   = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   // Slot tags.
   typedef enum logic [TAG_W-1:0] {
      TAG_EMPTY   = 2'd0,
      TAG_DELETED = 2'd1,
      TAG_LIVE    = 2'd2
   } tag_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_MOD,
      S_READ,
      S_CHECK,
      S_DONE
   } state_type;

endpackage

// File: hw/rtl/linear_probe_hash_set.sv
// An item first reduces the key to its home slot in the bit-serial modulo unit, then
// reads and checks each probed slot in turn, then loads the response.
// An insert into a full table and an unknown command skip the probe and go straight to the response.
// Throughput: one item at a time, set by the bit-serial modulo unit and the slot memory port.
// Reset: synchronous; after reset a clearing pass marks every slot empty, and no item
// is accepted until it ends. Configuration writes are taken outside reset.
module linear_probe_hash_set #(
   parameter int MAX_SLOTS = lphs_pkg::MAX_SLOTS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [lphs_pkg::CMD_W-1:0]    req_command,
   input  logic [lphs_pkg::KEY_W-1:0]    req_key,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [lphs_pkg::STATUS_W-1:0] rsp_status,
   output logic [lphs_pkg::COUNT_W-1:0]  rsp_occupied_count,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [lphs_pkg::SIZE_W-1:0]   csr_table_size
);

   localparam int IDX_W = $clog2(MAX_SLOTS);
   localparam int CAP_W = $clog2(MAX_SLOTS + 1);
   localparam int CMP_W = (CAP_W > lphs_pkg::SIZE_W) ? CAP_W : lphs_pkg::SIZE_W;
   localparam int SLOT_W = lphs_pkg::SLOT_W;
   localparam int KEY_W = lphs_pkg::KEY_W;

   lphs_pkg::state_type state_ff, state_in;

   logic [lphs_pkg::SIZE_W-1:0]   table_size_ff;
   logic [lphs_pkg::COUNT_W-1:0]  live_count_ff, live_count_in;
   logic [lphs_pkg::CMD_W-1:0]    cmd_ff, cmd_in;
   logic [KEY_W-1:0]              key_ff, key_in;
   logic [lphs_pkg::KEY_BIT_W-1:0] bit_ff, bit_in;
   logic [CAP_W-1:0]              rem_ff, rem_in;
   logic [IDX_W-1:0]              idx_ff, idx_in;
   logic [CAP_W-1:0]              probe_cnt_ff, probe_cnt_in;
   logic [IDX_W-1:0]              clr_idx_ff;
   logic [lphs_pkg::STATUS_W-1:0] status_ff, status_in;
   logic                          rsp_valid_ff;
   logic [lphs_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [lphs_pkg::COUNT_W-1:0]  rsp_count_ff;
   logic [SLOT_W-1:0]             rd_ff;

   logic [SLOT_W-1:0] mem [MAX_SLOTS];

   logic [CAP_W-1:0]  cap;
   logic [CMP_W-1:0]  size_ext;
   logic              accept;
   logic              rsp_free;
   logic              table_full;
   logic [CAP_W:0]    rem_shift;
   logic [CAP_W:0]    rem_next;
   logic [CAP_W-1:0]  idx_plus;
   logic [IDX_W-1:0]  idx_next;
   logic              last_probe;
   logic [lphs_pkg::TAG_W-1:0] rd_tag;
   logic [KEY_W-1:0]  rd_key;
   logic              rd_match;
   logic              chk_done;
   logic              mem_we;
   logic [IDX_W-1:0]  mem_addr;
   logic [SLOT_W-1:0] mem_wdata;

   // Size in use: zero reads as one, anything above the store depth as the depth.
   always_comb begin
      size_ext = CMP_W'(table_size_ff);
      if (size_ext == '0) begin
         cap = CAP_W'(1);
      end else if (size_ext > CMP_W'(MAX_SLOTS)) begin
         cap = CAP_W'(MAX_SLOTS);
      end else begin
         cap = CAP_W'(size_ext);
      end
   end

   assign req_ready  = (state_ff == lphs_pkg::S_IDLE);
   assign accept     = req_valid && req_ready;
   assign csr_ready  = !reset;
   assign rsp_free   = !rsp_valid_ff || rsp_ready;
   assign table_full = CMP_W'(live_count_ff) >= CMP_W'(cap);

   // Restoring step of the modulo unit: one key bit per cycle.
   assign rem_shift = {rem_ff, key_ff[bit_ff]};
   assign rem_next  = (rem_shift >= {1'b0, cap}) ? rem_shift - {1'b0, cap} : rem_shift;

   // Linear probe advance with wrap at the size in use.
   assign idx_plus   = CAP_W'(idx_ff) + CAP_W'(1);
   assign idx_next   = (idx_plus == cap) ? '0 : idx_plus[IDX_W-1:0];
   assign last_probe = (probe_cnt_ff == cap - CAP_W'(1));

   assign rd_tag   = rd_ff[SLOT_W-1 -: lphs_pkg::TAG_W];
   assign rd_key   = rd_ff[KEY_W-1:0];
   assign rd_match = (rd_tag == lphs_pkg::TAG_LIVE) && (rd_key == key_ff);

   // Probe decision for the slot just read, plus the clearing writes and the status preset in idle.
   always_comb begin
      chk_done      = 1'b0;
      status_in     = status_ff;
      live_count_in = live_count_ff;
      mem_we        = 1'b0;
      mem_addr      = idx_ff;
      mem_wdata     = {lphs_pkg::TAG_DELETED, key_ff};
      if (state_ff == lphs_pkg::S_CLEAR) begin
         mem_we    = 1'b1;
         mem_addr  = clr_idx_ff;
         mem_wdata = {lphs_pkg::TAG_EMPTY, {KEY_W{1'b0}}};
      end else if (state_ff == lphs_pkg::S_IDLE) begin
         if (req_command == lphs_pkg::CMD_INSERT) begin
            status_in = lphs_pkg::ST_FULL;
         end else begin
            status_in = lphs_pkg::ST_NOT_FOUND;
         end
      end else if (state_ff == lphs_pkg::S_CHECK) begin
         case (cmd_ff)
            lphs_pkg::CMD_INSERT: begin
               if (rd_match) begin
                  chk_done  = 1'b1;
                  status_in = lphs_pkg::ST_PRESENT;
               end else if (rd_tag != lphs_pkg::TAG_LIVE) begin
                  chk_done      = 1'b1;
                  status_in     = lphs_pkg::ST_OK;
                  mem_we        = 1'b1;
                  mem_wdata     = {lphs_pkg::TAG_LIVE, key_ff};
                  live_count_in = live_count_ff + 1'b1;
               end else if (last_probe) begin
                  chk_done  = 1'b1;
                  status_in = lphs_pkg::ST_FULL;
               end
            end
            default: begin
               if (rd_tag == lphs_pkg::TAG_EMPTY) begin
                  chk_done  = 1'b1;
                  status_in = lphs_pkg::ST_NOT_FOUND;
               end else if (rd_match) begin
                  chk_done  = 1'b1;
                  status_in = lphs_pkg::ST_OK;
                  if (cmd_ff == lphs_pkg::CMD_DELETE) begin
                     mem_we    = 1'b1;
                     mem_wdata = {lphs_pkg::TAG_DELETED, key_ff};
                     if (live_count_ff != '0) begin
                        live_count_in = live_count_ff - 1'b1;
                     end
                  end
               end else if (last_probe) begin
                  chk_done  = 1'b1;
                  status_in = lphs_pkg::ST_NOT_FOUND;
               end
            end
         endcase
      end
   end

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lphs_pkg::S_CLEAR: begin
            if (clr_idx_ff == IDX_W'(MAX_SLOTS - 1)) begin
               state_in = lphs_pkg::S_IDLE;
            end
         end
         lphs_pkg::S_IDLE: begin
            if (accept) begin
               if (req_command == lphs_pkg::CMD_SEARCH ||
                   req_command == lphs_pkg::CMD_DELETE ||
                   (req_command == lphs_pkg::CMD_INSERT && !table_full)) begin
                  state_in = lphs_pkg::S_MOD;
               end else begin
                  state_in = lphs_pkg::S_DONE;
               end
            end
         end
         lphs_pkg::S_MOD: begin
            if (bit_ff == '0) begin
               state_in = lphs_pkg::S_READ;
            end
         end
         lphs_pkg::S_READ: begin
            state_in = lphs_pkg::S_CHECK;
         end
         lphs_pkg::S_CHECK: begin
            state_in = chk_done ? lphs_pkg::S_DONE : lphs_pkg::S_READ;
         end
         lphs_pkg::S_DONE: begin
            if (rsp_free) begin
               state_in = lphs_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = lphs_pkg::S_IDLE;
         end
      endcase
   end

   // Working registers of the current item.
   always_comb begin
      cmd_in       = cmd_ff;
      key_in       = key_ff;
      bit_in       = bit_ff;
      rem_in       = rem_ff;
      idx_in       = idx_ff;
      probe_cnt_in = probe_cnt_ff;
      case (state_ff)
         lphs_pkg::S_IDLE: begin
            cmd_in = req_command;
            key_in = req_key;
            bit_in = lphs_pkg::KEY_BIT_W'(KEY_W - 1);
            rem_in = '0;
         end
         lphs_pkg::S_MOD: begin
            rem_in = rem_next[CAP_W-1:0];
            bit_in = bit_ff - 1'b1;
            if (bit_ff == '0) begin
               idx_in       = rem_next[IDX_W-1:0];
               probe_cnt_in = '0;
            end
         end
         lphs_pkg::S_CHECK: begin
            idx_in       = idx_next;
            probe_cnt_in = probe_cnt_ff + 1'b1;
         end
         default: begin
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= lphs_pkg::S_CLEAR;
         clr_idx_ff    <= '0;
         table_size_ff <= lphs_pkg::TABLE_SIZE_RESET;
         live_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         live_count_ff <= live_count_in;
         if (state_ff == lphs_pkg::S_CLEAR) begin
            clr_idx_ff <= clr_idx_ff + 1'b1;
         end
         if (csr_valid && csr_ready) begin
            table_size_ff <= csr_table_size;
         end
         if (state_ff == lphs_pkg::S_DONE && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      key_ff       <= key_in;
      bit_ff       <= bit_in;
      rem_ff       <= rem_in;
      idx_ff       <= idx_in;
      probe_cnt_ff <= probe_cnt_in;
      if (state_ff == lphs_pkg::S_IDLE || state_ff == lphs_pkg::S_CHECK) begin
         status_ff <= status_in;
      end
      if (state_ff == lphs_pkg::S_DONE && rsp_free) begin
         rsp_status_ff <= status_ff;
         rsp_count_ff  <= live_count_ff;
      end
   end

   // Slot memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      rd_ff <= mem[idx_ff];
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_occupied_count = rsp_count_ff;

endmodule

// File: dv/tb_linear_probe_hash_set.sv
`timescale 1ns / 100ps

module tb_linear_probe_hash_set;

   localparam int SLOT_COUNT = lphs_pkg::MAX_SLOTS_DEFAULT;
   localparam int STALL_LIMIT = 5000;
   localparam int DRAIN_CYCLES = 200;
   localparam logic [lphs_pkg::CMD_W-1:0] CMD_UNKNOWN = 2'd3;

   // One predicted response item.
   typedef struct packed {
      lphs_pkg::status_type         status;
      logic [lphs_pkg::COUNT_W-1:0] count;
   } set_result_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic [lphs_pkg::CMD_W-1:0]    req_command = '0;
   logic [lphs_pkg::KEY_W-1:0]    req_key = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic [lphs_pkg::STATUS_W-1:0] rsp_status;
   logic [lphs_pkg::COUNT_W-1:0]  rsp_occupied_count;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [lphs_pkg::SIZE_W-1:0]   csr_table_size = '0;

   // Shadow copy of the set: slot tags, slot keys, live count and table size.
   lphs_pkg::tag_type           shadow_tag [SLOT_COUNT];
   logic [lphs_pkg::KEY_W-1:0]  shadow_key [SLOT_COUNT];
   int unsigned                 shadow_live = 0;
   logic [lphs_pkg::SIZE_W-1:0] shadow_size = lphs_pkg::TABLE_SIZE_RESET;

   set_result_type set_results_due [$];
   int             error_count = 0;
   int             stall_cycles = 0;
   int             send_idle_pct = 0;
   int             recv_idle_pct = 0;

   linear_probe_hash_set dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_command        (req_command),
      .req_key            (req_key),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_occupied_count (rsp_occupied_count),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_table_size     (csr_table_size)
   );

   // Free-running 2 ns clock.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Slot count actually probed: zero acts as one, anything large is clipped.
   function automatic int unsigned slots_in_use();
      if (shadow_size == 0) begin
         return 1;
      end
      if (shadow_size > SLOT_COUNT) begin
         return SLOT_COUNT;
      end
      return int'(shadow_size);
   endfunction

   // Applies one request to the shadow set and returns the response it should produce.
   function automatic set_result_type apply_set_request(
         input logic [lphs_pkg::CMD_W-1:0] cmd,
         input logic [lphs_pkg::KEY_W-1:0] key);
      int unsigned    cap;
      int unsigned    idx;
      int unsigned    n;
      int             hit;
      set_result_type res;
      cap = slots_in_use();
      idx = 32'(key) % cap;
      hit = -1;
      res.status = lphs_pkg::ST_NOT_FOUND;
      if (cmd == lphs_pkg::CMD_SEARCH || cmd == lphs_pkg::CMD_DELETE) begin
         // Walk the probe chain until an empty slot, a match, or one full wrap.
         for (n = 0; n < cap; n++) begin
            if (shadow_tag[idx] == lphs_pkg::TAG_EMPTY) begin
               break;
            end
            if (shadow_tag[idx] == lphs_pkg::TAG_LIVE && shadow_key[idx] == key) begin
               hit = int'(idx);
               break;
            end
            idx = (idx + 1 == cap) ? 0 : idx + 1;
         end
         if (hit >= 0) begin
            res.status = lphs_pkg::ST_OK;
            if (cmd == lphs_pkg::CMD_DELETE) begin
               shadow_tag[hit] = lphs_pkg::TAG_DELETED;
               if (shadow_live > 0) begin
                  shadow_live--;
               end
            end
         end
      end else if (cmd == lphs_pkg::CMD_INSERT) begin
         res.status = lphs_pkg::ST_FULL;
         if (shadow_live < cap) begin
            // Take the first free slot, unless the key is already live earlier in the chain.
            for (n = 0; n < cap; n++) begin
               if (shadow_tag[idx] == lphs_pkg::TAG_LIVE && shadow_key[idx] == key) begin
                  res.status = lphs_pkg::ST_PRESENT;
                  break;
               end
               if (shadow_tag[idx] != lphs_pkg::TAG_LIVE) begin
                  shadow_tag[idx] = lphs_pkg::TAG_LIVE;
                  shadow_key[idx] = key;
                  shadow_live++;
                  res.status = lphs_pkg::ST_OK;
                  break;
               end
               idx = (idx + 1 == cap) ? 0 : idx + 1;
            end
         end
      end
      res.count = lphs_pkg::COUNT_W'(shadow_live);
      return res;
   endfunction

   task automatic report_mismatch(input string msg);
      if (error_count < 100) begin
         $display("mismatch at %0t ns: %s", $realtime, msg);
      end
      error_count++;
   endtask

   // Predict a response for every request item taken by the block.
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         set_results_due.push_back(apply_set_request(req_command, req_key));
      end
   end

   // Track the table size register.
   always @(posedge clock) begin
      if (!reset && csr_valid && csr_ready) begin
         shadow_size <= csr_table_size;
      end
   end

   // Compare every response item with the oldest prediction.
   always @(posedge clock) begin : check_response
      set_result_type due;
      if (!reset && rsp_valid && rsp_ready) begin
         if (set_results_due.size() == 0) begin
            report_mismatch("response item with no request waiting");
         end else begin
            due = set_results_due.pop_front();
            if (rsp_status !== due.status) begin
               report_mismatch($sformatf("status %0d, expected %s", rsp_status,
                                         due.status.name()));
            end
            if (rsp_occupied_count !== due.count) begin
               report_mismatch($sformatf("occupied count %0d, expected %0d",
                                         rsp_occupied_count, due.count));
            end
         end
      end
   end

   // Response side backpressure.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // Watchdog: end the run if no channel moves an item for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("[linear_probe_hash_set] ERROR");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Presents one request item and holds it until the block takes it.
   task automatic send_request(input logic [lphs_pkg::CMD_W-1:0] cmd,
                               input logic [lphs_pkg::KEY_W-1:0] key);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_valid   <= 1'b1;
      req_command <= cmd;
      req_key     <= key;
      do @(posedge clock); while (!req_ready);
   endtask

   // Stops sending and waits until every predicted response has arrived.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (set_results_due.size() != 0);
      @(posedge clock);
   endtask

   task automatic write_table_size(input logic [lphs_pkg::SIZE_W-1:0] size);
      csr_valid      <= 1'b1;
      csr_table_size <= size;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Mostly small sizes, sometimes mid-range, now and then the extremes.
   function automatic logic [lphs_pkg::SIZE_W-1:0] pick_table_size();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) begin
         return lphs_pkg::SIZE_W'($urandom_range(1, 12));
      end else if (r < 85) begin
         return lphs_pkg::SIZE_W'($urandom_range(13, 64));
      end else if (r < 95) begin
         return lphs_pkg::SIZE_W'($urandom_range(65, 127));
      end
      return '0;
   endfunction

   // Keys from a small pool for hits, large keys sharing home slots, and full-range noise.
   function automatic logic [lphs_pkg::KEY_W-1:0] pick_key();
      int unsigned cap;
      int unsigned k;
      int          r;
      cap = slots_in_use();
      r = $urandom_range(0, 99);
      if (r < 65) begin
         return lphs_pkg::KEY_W'($urandom_range(0, 3 * cap + 2));
      end else if (r < 85) begin
         k = $urandom_range(0, 32'h7FFF_FF00);
         return lphs_pkg::KEY_W'(k - (k % cap) + $urandom_range(0, 2));
      end
      return lphs_pkg::KEY_W'($urandom);
   endfunction

   // Requests against the empty table right after reset.
   task automatic test_empty_table();
      send_request(lphs_pkg::CMD_SEARCH, '0);
      send_request(lphs_pkg::CMD_DELETE, '1);
      send_request(CMD_UNKNOWN, '1);
      send_request(lphs_pkg::CMD_INSERT, '1);
      send_request(CMD_UNKNOWN, '0);
   endtask

   // Duplicates, collisions, passing over deleted slots and reusing them.
   task automatic test_insert_probe();
      send_request(lphs_pkg::CMD_INSERT, 31'd0);
      send_request(lphs_pkg::CMD_INSERT, 31'd0);
      send_request(lphs_pkg::CMD_INSERT, 31'd64);
      send_request(lphs_pkg::CMD_SEARCH, 31'd64);
      send_request(lphs_pkg::CMD_DELETE, 31'd0);
      send_request(lphs_pkg::CMD_SEARCH, 31'd64);
      send_request(lphs_pkg::CMD_SEARCH, 31'd0);
      send_request(lphs_pkg::CMD_INSERT, 31'd128);
      send_request(lphs_pkg::CMD_SEARCH, '1);
      send_request(lphs_pkg::CMD_DELETE, 31'd5);
   endtask

   // Size zero, one, the clipped values and full tables, with live keys left outside.
   task automatic test_size_limits();
      wait_for_drain();
      write_table_size('0);
      send_request(lphs_pkg::CMD_INSERT, 31'd7);
      send_request(lphs_pkg::CMD_SEARCH, 31'd128);
      send_request(lphs_pkg::CMD_DELETE, 31'd128);
      wait_for_drain();
      write_table_size(7'd1);
      send_request(lphs_pkg::CMD_SEARCH, 31'd0);
      wait_for_drain();
      write_table_size('1);
      send_request(lphs_pkg::CMD_SEARCH, 31'd64);
      send_request(lphs_pkg::CMD_DELETE, 31'd64);
      wait_for_drain();
      write_table_size(7'd65);
      send_request(lphs_pkg::CMD_INSERT, 31'd65);
      wait_for_drain();
      write_table_size(7'd4);
      send_request(lphs_pkg::CMD_INSERT, 31'd2);
      send_request(lphs_pkg::CMD_INSERT, 31'd6);
   endtask

   // Random requests, with occasional full drains that may retune the table size.
   task automatic test_random_traffic(input int items, input int send_pct, input int recv_pct);
      int                         i;
      int                         r;
      logic [lphs_pkg::CMD_W-1:0] cmd;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      wait_for_drain();
      write_table_size(pick_table_size());
      for (i = 0; i < items; i++) begin
         if ($urandom_range(0, 39) == 0) begin
            wait_for_drain();
            if ($urandom_range(0, 1) == 1) begin
               write_table_size(pick_table_size());
            end
         end
         r = $urandom_range(0, 99);
         if (r < 40) begin
            cmd = lphs_pkg::CMD_INSERT;
         end else if (r < 65) begin
            cmd = lphs_pkg::CMD_DELETE;
         end else if (r < 95) begin
            cmd = lphs_pkg::CMD_SEARCH;
         end else begin
            cmd = CMD_UNKNOWN;
         end
         send_request(cmd, pick_key());
      end
   endtask

   initial begin
      for (int s = 0; s < SLOT_COUNT; s++) begin
         shadow_tag[s] = lphs_pkg::TAG_EMPTY;
         shadow_key[s] = '0;
      end
      send_idle_pct = 29;
      recv_idle_pct = 50;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_empty_table();
      test_insert_probe();
      test_size_limits();
      test_random_traffic(200, 29, 50);
      test_random_traffic(200, 50, 29);
      test_random_traffic(200, 0, 0);

      // Let the last responses come and give the block time to show any extra item.
      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && set_results_due.size() == 0) begin
         $display("[linear_probe_hash_set] OK");
      end else begin
         $display("[linear_probe_hash_set] ERROR");
      end
      $finish;
   end

endmodule

// File: files.f
hw/rtl/lphs_pkg.sv
hw/rtl/linear_probe_hash_set.sv
dv/tb_linear_probe_hash_set.sv
